/* hdl/u8u16_pkg.sv */
// Types and constants shared by the UTF-8 to UTF-16 decoder modules.
// No dependencies.
`default_nettype none

package u8u16_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_UTF8 = 2'd1;
	localparam logic [1:0] ST_CAPACITY = 2'd2;

	localparam logic [15:0] CAP_RESET     = 16'hFFFF;
	localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
	localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
	localparam logic [20:0] SURR_FIRST    = 21'h00D800;
	localparam logic [20:0] SURR_END      = 21'h00E000;
	localparam logic [20:0] SUPP_BASE     = 21'h010000;
	localparam logic [20:0] CODE_MAX      = 21'h10FFFF;

	typedef struct packed {
		logic [15:0] word;
		logic [9:0]  lo;
		logic        pair;
		logic        last;
		logic [1:0]  status;
		logic [15:0] count;
	} entry_t;

endpackage

`default_nettype wire

/* hdl/u8u16_front.sv */
// Front end: accepts bytes, tracks string state and classifies each byte into a queue entry.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [7:0]        in_byte,
	input  wire logic              full,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_data,
	output logic                   push,
	output u8u16_pkg::entry_t      push_entry
);
	import u8u16_pkg::*;

	logic [20:0] acc_q, acc_n, acc_sh, ch_off;
	logic [1:0]  pend_q, pend_n;
	logic [15:0] ww_q, ww_n;
	logic        disc_q, disc_n;
	logic [15:0] cap_q;
	logic [16:0] ww_p1;
	logic        accept, emit, fail, clr;
	logic [1:0]  fstat;
	entry_t      ent;

	assign accept = in_valid && !full;
	assign acc_sh = {acc_q[14:0], in_byte[5:0]};
	assign ch_off = acc_sh - SUPP_BASE;
	assign ww_p1  = {1'b0, ww_q} + 17'd1;

	always_comb begin
		acc_n  = acc_q;
		pend_n = pend_q;
		ww_n   = ww_q;
		disc_n = disc_q;
		emit   = 1'b0;
		fail   = 1'b0;
		clr    = 1'b0;
		fstat  = ST_OK;
		ent    = '0;
		if (disc_q) begin
			if (in_byte == 8'h00) begin
				disc_n = 1'b0;
				clr    = 1'b1;
			end
		end else if (pend_q != 2'd0) begin
			if (in_byte[7:6] != 2'b10) begin
				fail  = 1'b1;
				fstat = ST_BAD_UTF8;
			end else begin
				acc_n  = acc_sh;
				pend_n = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					acc_n = '0;
					if (acc_sh >= SURR_FIRST && acc_sh < SURR_END) begin
						fail  = 1'b1;
						fstat = ST_BAD_UTF8;
					end else if (acc_sh == '0 || acc_sh > CODE_MAX) begin
						fail  = 1'b1;
						fstat = ST_BAD_UTF8;
					end else if (ww_q >= cap_q) begin
						fail  = 1'b1;
						fstat = ST_CAPACITY;
					end else if (acc_sh < SUPP_BASE) begin
						emit     = 1'b1;
						ent.word = acc_sh[15:0];
						ww_n     = ww_q + 16'd1;
					end else if (ww_p1 >= {1'b0, cap_q}) begin
						fail  = 1'b1;
						fstat = ST_CAPACITY;
					end else begin
						emit     = 1'b1;
						ent.pair = 1'b1;
						ent.word = HI_SURR_BASE + {6'd0, ch_off[19:10]};
						ent.lo   = ch_off[9:0];
						ww_n     = ww_q + 16'd2;
					end
				end
			end
		end else if (in_byte == 8'h00) begin
			if (ww_q >= cap_q) begin
				fail  = 1'b1;
				fstat = ST_CAPACITY;
			end else begin
				emit      = 1'b1;
				ent.last  = 1'b1;
				ent.count = ww_q;
				clr       = 1'b1;
			end
		end else if (in_byte inside {[8'hF0:8'hF7]}) begin
			acc_n  = {18'd0, in_byte[2:0]};
			pend_n = 2'd3;
		end else if (in_byte inside {[8'hE0:8'hEF]}) begin
			acc_n  = {17'd0, in_byte[3:0]};
			pend_n = 2'd2;
		end else if (in_byte inside {[8'hC0:8'hDF]}) begin
			acc_n  = {16'd0, in_byte[4:0]};
			pend_n = 2'd1;
		end else if (in_byte[7]) begin
			fail  = 1'b1;
			fstat = ST_BAD_UTF8;
		end else if (ww_q >= cap_q) begin
			fail  = 1'b1;
			fstat = ST_CAPACITY;
		end else begin
			emit     = 1'b1;
			ent.word = {8'd0, in_byte};
			ww_n     = ww_q + 16'd1;
		end
		if (fail) begin
			emit       = 1'b1;
			ent        = '0;
			ent.last   = 1'b1;
			ent.status = fstat;
			clr        = 1'b1;
			disc_n     = (in_byte != 8'h00);
		end
		if (clr) begin
			acc_n  = '0;
			pend_n = '0;
			ww_n   = '0;
		end
	end

	assign push       = accept && emit;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
			ww_q   <= '0;
			disc_q <= 1'b0;
			cap_q  <= CAP_RESET;
		end else begin
			if (accept) begin
				acc_q  <= acc_n;
				pend_q <= pend_n;
				ww_q   <= ww_n;
				disc_q <= disc_n;
			end
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/u8u16_queue.sv */
// Short register queue between the front and back ends.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire u8u16_pkg::entry_t push_entry,
	input  wire logic              pop,
	output u8u16_pkg::entry_t      head,
	output logic                   empty,
	output logic                   full
);
	import u8u16_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(DEPTH));
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/u8u16_back.sv */
// Back end: drains queue entries into the output register, splitting surrogate pairs.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire u8u16_pkg::entry_t head,
	input  wire logic              empty,
	output logic                   pop,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic [15:0]            out_word,
	output logic                   is_last,
	output logic [1:0]             status,
	output logic [15:0]            word_count
);
	import u8u16_pkg::*;

	logic        valid_q, half_q, load;
	logic [15:0] word_q, count_q;
	logic        last_q;
	logic [1:0]  status_q;

	assign load = !valid_q || !out_stall;
	assign pop  = load && !empty && (!head.pair || half_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty && head.pair) begin
				half_q <= !half_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			word_q   <= (head.pair && half_q) ? (LO_SURR_BASE | {6'd0, head.lo}) : head.word;
			last_q   <= head.last;
			status_q <= head.status;
			count_q  <= head.count;
		end
	end

	assign out_valid  = valid_q;
	assign out_word   = word_q;
	assign is_last    = last_q;
	assign status     = status_q;
	assign word_count = count_q;

endmodule

`default_nettype wire

/* hdl/utf8_to_utf16_stream_decoder.sv */
// Top level of the UTF-8 to UTF-16 stream decoder: front end, entry queue, back end.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
//
//   port group   dir  handshake            payload
//   in           in   in_valid/in_stall    in_byte
//   out          out  out_valid/out_stall  out_word, is_last, status, word_count
//   cfg          in   cfg_we               cfg_data (capacity_words)
//
// One byte is taken per cycle while the queue has room; each byte is decoded in that cycle.
// A surrogate pair occupies the output register for its high and low halves in turn, so the queue fills
// only when pairs or output stalls outpace input; QUEUE_DEPTH sets the slack.
// Each result passes through a queue slot and then the output register.
// arst_n clears string state, queue and output valid; capacity resets to 65535.
`default_nettype none

module utf8_to_utf16_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      out_word,
	output logic             is_last,
	output logic [1:0]       status,
	output logic [15:0]      word_count,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data
);
	import u8u16_pkg::*;

	entry_t push_entry, head;
	logic   push, pop, empty, full;

	assign in_stall = full;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.full       (full),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_entry (push_entry)
	);

	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_word   (out_word),
		.is_last    (is_last),
		.status     (status),
		.word_count (word_count)
	);

endmodule

`default_nettype wire

/* hdl/u8u16_checker.sv */
// Port-level checks for the decoder, bound to the top level.
// Depends on u8u16_pkg and utf8_to_utf16_stream_decoder.
`default_nettype none

module u8u16_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  in_byte,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] out_word,
	input wire logic        is_last,
	input wire logic [1:0]  status,
	input wire logic [15:0] word_count,
	input wire logic        cfg_we,
	input wire logic [15:0] cfg_data
);
	import u8u16_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(is_last)
			&& $stable(status) && $stable(word_count))
		else $error("stalled result changed");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> is_last && word_count == 16'd0)
		else $error("error result not final or carries a count");

	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> out_word == 16'd0)
		else $error("final result with nonzero word");

	a_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> status == ST_OK && word_count == 16'd0)
		else $error("word result with status or count");

	a_lo_follows_hi: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !is_last && out_word[15:10] == 6'b110110
			|=> out_valid && !is_last && out_word[15:10] == 6'b110111)
		else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_stream_decoder u8u16_checker u_chk (.*);

`default_nettype wire
